FILE: rtl/core/ray_box_slab_intersect_macros.svh
// Assertion macros for the ray/box slab test block.
`ifndef RAY_BOX_SLAB_INTERSECT_MACROS_SVH
`define RAY_BOX_SLAB_INTERSECT_MACROS_SVH

// Same-cycle implication, held off while reset is asserted.
`define RBSI_ASSERT_IMPL(lbl, clk, rst_n, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
		else $error("%m: check failed");

// Next-cycle implication, held off while reset is asserted.
`define RBSI_ASSERT_NEXT(lbl, clk, rst_n, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
		else $error("%m: check failed");

`endif

FILE: rtl/core/rbsi_pkg.sv
// ----------------------------------------------------------------------------
// rbsi_pkg
// Shared constants, queue status type and entry layout of the slab test.
// ----------------------------------------------------------------------------
package rbsi_pkg;

	localparam int COORD_WIDTH_DEF   = 32;
	localparam int FRACTION_BITS_DEF = 16;
	localparam int FIELD_WIDTH       = 32;
	localparam int PAIR_WIDTH        = 64;
	localparam int DIST_WIDTH        = 31;
	localparam int FIFO_DEPTH        = 4;

	typedef struct packed {
		logic full;
		logic empty;
	} fifo_status_t;

	// per axis: mag_lo, mag_hi (cw+1 each), neg_lo, neg_hi, dmag, d (cw each), dzero
	function automatic int axis_w(input int cw);
		return 4 * cw + 5;
	endfunction

	// three axes, parallel-miss flag, distance limit
	function automatic int entry_w(input int cw);
		return 3 * axis_w(cw) + 1 + DIST_WIDTH;
	endfunction

endpackage

FILE: rtl/core/rbsi_fifo.sv
// ----------------------------------------------------------------------------
// rbsi_fifo
// Short flop-based queue between the classify front and the divide back.
// ----------------------------------------------------------------------------
module rbsi_fifo #(
	parameter int WIDTH = 8
) (
	input  logic                       clk,
	input  logic                       arst_n,
	input  logic                       push,
	input  logic [WIDTH-1:0]           push_data,
	input  logic                       pop,
	output logic [WIDTH-1:0]           pop_data,
	output rbsi_pkg::fifo_status_t     status
);
	import rbsi_pkg::*;

	localparam int PW = $clog2(FIFO_DEPTH);

	logic [WIDTH-1:0] mem_q [FIFO_DEPTH];
	logic [PW-1:0]    wr_q;
	logic [PW-1:0]    rd_q;
	logic [PW:0]      count_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_q    <= '0;
			rd_q    <= '0;
			count_q <= '0;
		end else begin
			if (push) wr_q <= wr_q + 1'b1;
			if (pop)  rd_q <= rd_q + 1'b1;
			if (push && !pop)      count_q <= count_q + 1'b1;
			else if (pop && !push) count_q <= count_q - 1'b1;
		end
	end

	always_ff @(posedge clk) begin
		if (push) mem_q[wr_q] <= push_data;
	end

	assign pop_data     = mem_q[rd_q];
	assign status.full  = (count_q == (PW+1)'(FIFO_DEPTH));
	assign status.empty = (count_q == '0);

endmodule

FILE: rtl/core/rbsi_front.sv
// ----------------------------------------------------------------------------
// rbsi_front
// Accept a ray, classify each slab (parallel, outside) and form the
// numerator magnitudes and quotient signs for the divide back end.
// ----------------------------------------------------------------------------
module rbsi_front #(
	parameter int COORD_WIDTH   = rbsi_pkg::COORD_WIDTH_DEF
) (
	input  logic                                          clk,
	input  logic                                          arst_n,
	input  logic                                          in_valid,
	output logic                                          in_stall,
	input  logic signed [rbsi_pkg::FIELD_WIDTH-1:0]       origin_x,
	input  logic signed [rbsi_pkg::FIELD_WIDTH-1:0]       org_y,
	input  logic signed [rbsi_pkg::FIELD_WIDTH-1:0]       origin_z,
	input  logic signed [rbsi_pkg::FIELD_WIDTH-1:0]       dir_x,
	input  logic signed [rbsi_pkg::FIELD_WIDTH-1:0]       dir_y,
	input  logic signed [rbsi_pkg::FIELD_WIDTH-1:0]       dir_z,
	input  logic signed [rbsi_pkg::FIELD_WIDTH-1:0]       box_min_x,
	input  logic signed [rbsi_pkg::FIELD_WIDTH-1:0]       box_min_y,
	input  logic signed [rbsi_pkg::FIELD_WIDTH-1:0]       box_min_z,
	input  logic signed [rbsi_pkg::FIELD_WIDTH-1:0]       box_max_x,
	input  logic signed [rbsi_pkg::PAIR_WIDTH-1:0]        box_max_yz_pair,
	input  logic [rbsi_pkg::DIST_WIDTH-1:0]               dist_limit,
	output logic                                          push,
	output logic [rbsi_pkg::entry_w(COORD_WIDTH)-1:0]     push_data,
	input  rbsi_pkg::fifo_status_t                        status
);
	import rbsi_pkg::*;

	localparam int CW  = COORD_WIDTH;
	localparam int AXW = axis_w(CW);

	logic                  valid_s1;
	logic signed [CW-1:0]  o_s1  [3];
	logic signed [CW-1:0]  d_s1  [3];
	logic signed [CW-1:0]  lo_s1 [3];
	logic signed [CW-1:0]  hi_s1 [3];
	logic [DIST_WIDTH-1:0] tmax_s1;
	logic [2:0]            par_miss;
	logic                  accept;

	assign in_stall = valid_s1 && status.full;
	assign accept   = in_valid && !in_stall;
	assign push     = valid_s1 && !status.full;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (accept) begin
			valid_s1 <= 1'b1;
		end else if (push) begin
			valid_s1 <= 1'b0;
		end
	end

	// only the low coordinate bits count, taken as signed
	always_ff @(posedge clk) begin
		if (accept) begin
			o_s1[0]  <= origin_x[CW-1:0];
			o_s1[1]  <= org_y[CW-1:0];
			o_s1[2]  <= origin_z[CW-1:0];
			d_s1[0]  <= dir_x[CW-1:0];
			d_s1[1]  <= dir_y[CW-1:0];
			d_s1[2]  <= dir_z[CW-1:0];
			lo_s1[0] <= box_min_x[CW-1:0];
			lo_s1[1] <= box_min_y[CW-1:0];
			lo_s1[2] <= box_min_z[CW-1:0];
			hi_s1[0] <= box_max_x[CW-1:0];
			hi_s1[1] <= box_max_yz_pair[FIELD_WIDTH +: CW];
			hi_s1[2] <= box_max_yz_pair[CW-1:0];
			tmax_s1  <= dist_limit;
		end
	end

	for (genvar a = 0; a < 3; a++) begin : g_axis
		logic signed [CW:0]  lo_p, lo_n, hi_p, hi_n;
		logic [CW:0]         mag_lo, mag_hi;
		logic                neg_lo, neg_hi, dzero;
		logic [CW-1:0]       dmag;

		// both differences in parallel, pick the non-negative one
		assign lo_p   = {lo_s1[a][CW-1], lo_s1[a]} - {o_s1[a][CW-1], o_s1[a]};
		assign lo_n   = {o_s1[a][CW-1], o_s1[a]} - {lo_s1[a][CW-1], lo_s1[a]};
		assign hi_p   = {hi_s1[a][CW-1], hi_s1[a]} - {o_s1[a][CW-1], o_s1[a]};
		assign hi_n   = {o_s1[a][CW-1], o_s1[a]} - {hi_s1[a][CW-1], hi_s1[a]};
		assign mag_lo = lo_p[CW] ? lo_n : lo_p;
		assign mag_hi = hi_p[CW] ? hi_n : hi_p;
		assign neg_lo = lo_p[CW] ^ d_s1[a][CW-1];
		assign neg_hi = hi_p[CW] ^ d_s1[a][CW-1];
		assign dmag   = d_s1[a][CW-1] ? -d_s1[a] : d_s1[a];
		assign dzero  = (d_s1[a] == '0);

		assign par_miss[a] = dzero && ((o_s1[a] < lo_s1[a]) || (o_s1[a] > hi_s1[a]));
		assign push_data[a*AXW +: AXW] =
			{dzero, d_s1[a], dmag, neg_hi, neg_lo, mag_hi, mag_lo};
	end

	assign push_data[3*AXW +: 1+DIST_WIDTH] = {tmax_s1, |par_miss};

endmodule

FILE: rtl/core/rbsi_div.sv
// ----------------------------------------------------------------------------
// rbsi_div
// Unsigned restoring divider, one quotient bit per pipeline stage.
// ----------------------------------------------------------------------------
module rbsi_div #(
	parameter int NW = 49,
	parameter int DW = 32
) (
	input  logic          clk,
	input  logic          en,
	input  logic [NW-1:0] num,
	input  logic [DW-1:0] den,
	output logic [NW-1:0] quo
);
	logic [DW-1:0] rem_q [NW-1];
	logic [DW-1:0] den_q [NW-1];
	logic [NW-1:0] quo_q [NW];

	for (genvar k = 0; k < NW; k++) begin : g_stage
		logic [DW-1:0] rem_in, den_in;
		logic [NW-1:0] n_in;
		logic [DW:0]   sh, trial;

		if (k == 0) begin : g_first
			assign rem_in = '0;
			assign n_in   = num;
			assign den_in = den;
		end else begin : g_next
			assign rem_in = rem_q[k-1];
			assign n_in   = quo_q[k-1];
			assign den_in = den_q[k-1];
		end

		assign sh    = {rem_in, n_in[NW-1]};
		assign trial = sh - {1'b0, den_in};

		always_ff @(posedge clk) begin
			if (en) quo_q[k] <= {n_in[NW-2:0], !trial[DW]};
		end

		if (k < NW-1) begin : g_rem
			always_ff @(posedge clk) begin
				if (en) begin
					rem_q[k] <= trial[DW] ? sh[DW-1:0] : trial[DW-1:0];
					den_q[k] <= den_in;
				end
			end
		end
	end

	assign quo = quo_q[NW-1];

endmodule

FILE: rtl/core/rbsi_back.sv
// ----------------------------------------------------------------------------
// rbsi_back
// Divide, saturate, order each slab and walk x, y, z to the final result.
// ----------------------------------------------------------------------------
module rbsi_back #(
	parameter int COORD_WIDTH   = rbsi_pkg::COORD_WIDTH_DEF,
	parameter int FRACTION_BITS = rbsi_pkg::FRACTION_BITS_DEF
) (
	input  logic                                        clk,
	input  logic                                        arst_n,
	input  rbsi_pkg::fifo_status_t                      status,
	output logic                                        pop,
	input  logic [rbsi_pkg::entry_w(COORD_WIDTH)-1:0]   pop_data,
	output logic                                        out_valid,
	input  logic                                        out_stall,
	output logic                                        hit,
	output logic [rbsi_pkg::DIST_WIDTH-1:0]             entry_distance,
	output logic signed [rbsi_pkg::FIELD_WIDTH-1:0]     normal_x,
	output logic signed [rbsi_pkg::FIELD_WIDTH-1:0]     normal_y,
	output logic signed [rbsi_pkg::FIELD_WIDTH-1:0]     normal_z
);
	import rbsi_pkg::*;

	localparam int CW   = COORD_WIDTH;
	localparam int FB   = FRACTION_BITS;
	localparam int NW   = CW + 1 + FB;
	localparam int AXW  = axis_w(CW);
	localparam int SAW  = CW + 3;
	localparam int SW   = 3 * SAW + 1 + DIST_WIDTH;
	localparam int TW   = FIELD_WIDTH;

	localparam logic signed [CW-1:0] CMAX = {1'b0, {(CW-1){1'b1}}};
	localparam logic signed [CW-1:0] CMIN = {1'b1, {(CW-1){1'b0}}};
	localparam logic signed [CW-1:0] UNIT =
		(FB >= CW-1) ? CMAX : ((CW)'(1) << FB);

	localparam logic [1:0] AXIS_X    = 2'd0;
	localparam logic [1:0] AXIS_Y    = 2'd1;
	localparam logic [1:0] AXIS_Z    = 2'd2;
	localparam logic [1:0] AXIS_NONE = 2'd3;

	typedef struct packed {
		logic signed [TW-1:0] tmin;
		logic signed [TW-1:0] tmax;
		logic [1:0]           axis;
		logic                 sign;
		logic                 miss;
	} walk_t;

	function automatic logic signed [CW-1:0] sat_q(input logic [NW-1:0] q, input logic neg);
		logic big;
		big = |q[NW-1:CW-1];
		if (big) return neg ? CMIN : CMAX;
		return neg ? -$signed(q[CW-1:0]) : $signed(q[CW-1:0]);
	endfunction

	// one slab narrows the interval; the entry axis moves only on a strict raise
	function automatic walk_t walk_step(input walk_t w, input logic signed [CW-1:0] tn,
		input logic signed [CW-1:0] tx, input logic sgn, input logic dzero,
		input logic [1:0] code);
		walk_t r;
		logic signed [TW-1:0] e, x;
		r = w;
		e = TW'(tn);
		x = TW'(tx);
		if (!dzero) begin
			if (e > w.tmin) begin
				r.tmin = e;
				r.axis = code;
				r.sign = sgn;
			end
			if (x < w.tmax) r.tmax = x;
			if (r.tmin > r.tmax) r.miss = 1'b1;
		end
		return r;
	endfunction

	logic advance;
	logic out_valid_q;

	assign advance = !out_valid_q || !out_stall;
	assign pop     = advance && !status.empty;

	// ---- divider feed ----
	logic [CW:0]          mag_lo [3];
	logic [CW:0]          mag_hi [3];
	logic [NW-1:0]        q_lo   [3];
	logic [NW-1:0]        q_hi   [3];
	logic [CW-1:0]        dmag   [3];
	logic [SW-1:0]        side_in;
	logic [SW-1:0]        side_q [NW];
	logic [NW-1:0]        vld_q;

	for (genvar a = 0; a < 3; a++) begin : g_div
		logic              neg_lo, neg_hi, dzero;
		logic signed [CW-1:0] d;

		assign {dzero, d, dmag[a], neg_hi, neg_lo, mag_hi[a], mag_lo[a]} =
			pop_data[a*AXW +: AXW];
		assign side_in[a*SAW +: SAW] = {dzero, d, neg_hi, neg_lo};

		rbsi_div #(.NW(NW), .DW(CW)) u_div_lo (
			.clk (clk),
			.en  (advance),
			.num ({mag_lo[a], {FB{1'b0}}}),
			.den (dmag[a]),
			.quo (q_lo[a])
		);

		rbsi_div #(.NW(NW), .DW(CW)) u_div_hi (
			.clk (clk),
			.en  (advance),
			.num ({mag_hi[a], {FB{1'b0}}}),
			.den (dmag[a]),
			.quo (q_hi[a])
		);
	end

	assign side_in[3*SAW +: 1+DIST_WIDTH] = pop_data[3*AXW +: 1+DIST_WIDTH];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_q <= '0;
		end else if (advance) begin
			vld_q <= {vld_q[NW-2:0], pop};
		end
	end

	always_ff @(posedge clk) begin
		if (advance) begin
			side_q[0] <= side_in;
			for (int k = 1; k < NW; k++) side_q[k] <= side_q[k-1];
		end
	end

	// ---- saturate, order, then walk ----
	logic                  valid_s1, valid_s2, valid_s3, valid_s4;
	logic signed [CW-1:0]  t0_s1 [3];
	logic signed [CW-1:0]  t1_s1 [3];
	logic signed [CW-1:0]  d_s1  [3];
	logic [2:0]            dzero_s1, dzero_s2, dzero_s3, dzero_s4;
	logic                  miss_s1, miss_s2;
	logic [DIST_WIDTH-1:0] tmax_s1, tmax_s2;
	logic signed [CW-1:0]  tn_s2 [3];
	logic signed [CW-1:0]  tx_s2 [3];
	logic signed [CW-1:0]  tn_s3 [3];
	logic signed [CW-1:0]  tx_s3 [3];
	logic signed [CW-1:0]  tn_s4 [3];
	logic signed [CW-1:0]  tx_s4 [3];
	logic [2:0]            sgn_s2, sgn_s3, sgn_s4;
	logic signed [CW-1:0]  negd_s2 [3];
	logic signed [CW-1:0]  negd_s3 [3];
	logic signed [CW-1:0]  negd_s4 [3];
	walk_t                 walk_init, walk_s3, walk_s4, walk_fin;
	logic signed [CW-1:0]  nrm [3];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1    <= 1'b0;
			valid_s2    <= 1'b0;
			valid_s3    <= 1'b0;
			valid_s4    <= 1'b0;
			out_valid_q <= 1'b0;
		end else if (advance) begin
			valid_s1    <= vld_q[NW-1];
			valid_s2    <= valid_s1;
			valid_s3    <= valid_s2;
			valid_s4    <= valid_s3;
			out_valid_q <= valid_s4;
		end
	end

	always_ff @(posedge clk) begin
		if (advance) begin
			for (int a = 0; a < 3; a++) begin
				t0_s1[a]    <= sat_q(q_lo[a], side_q[NW-1][a*SAW]);
				t1_s1[a]    <= sat_q(q_hi[a], side_q[NW-1][a*SAW+1]);
				d_s1[a]     <= side_q[NW-1][a*SAW+2 +: CW];
				dzero_s1[a] <= side_q[NW-1][a*SAW+CW+2];
			end
			{tmax_s1, miss_s1} <= side_q[NW-1][3*SAW +: 1+DIST_WIDTH];

			for (int a = 0; a < 3; a++) begin
				if (t0_s1[a] > t1_s1[a]) begin
					tn_s2[a]  <= t1_s1[a];
					tx_s2[a]  <= t0_s1[a];
					sgn_s2[a] <= 1'b1;
				end else begin
					tn_s2[a]  <= t0_s1[a];
					tx_s2[a]  <= t1_s1[a];
					sgn_s2[a] <= 1'b0;
				end
				negd_s2[a] <= (d_s1[a] == CMIN) ? CMAX : -d_s1[a];
			end
			dzero_s2 <= dzero_s1;
			miss_s2  <= miss_s1;
			tmax_s2  <= tmax_s1;

			walk_s3  <= walk_step(walk_init, tn_s2[0], tx_s2[0], sgn_s2[0], dzero_s2[0],
				AXIS_X);
			tn_s3    <= tn_s2;
			tx_s3    <= tx_s2;
			sgn_s3   <= sgn_s2;
			dzero_s3 <= dzero_s2;
			negd_s3  <= negd_s2;

			walk_s4  <= walk_step(walk_s3, tn_s3[1], tx_s3[1], sgn_s3[1], dzero_s3[1],
				AXIS_Y);
			tn_s4    <= tn_s3;
			tx_s4    <= tx_s3;
			sgn_s4   <= sgn_s3;
			dzero_s4 <= dzero_s3;
			negd_s4  <= negd_s3;

			hit            <= !walk_fin.miss;
			entry_distance <= walk_fin.miss ? '0 : walk_fin.tmin[DIST_WIDTH-1:0];
			normal_x       <= TW'(nrm[0]);
			normal_y       <= TW'(nrm[1]);
			normal_z       <= TW'(nrm[2]);
		end
	end

	always_comb begin
		walk_init.tmin = '0;
		walk_init.tmax = TW'({1'b0, tmax_s2});
		walk_init.axis = AXIS_NONE;
		walk_init.sign = 1'b0;
		walk_init.miss = miss_s2;
	end

	always_comb begin
		walk_fin = walk_step(walk_s4, tn_s4[2], tx_s4[2], sgn_s4[2], dzero_s4[2], AXIS_Z);
		for (int a = 0; a < 3; a++) begin
			if (walk_fin.miss) begin
				nrm[a] = '0;
			end else if (walk_fin.axis == AXIS_NONE) begin
				nrm[a] = negd_s4[a];
			end else if (walk_fin.axis == 2'(a)) begin
				nrm[a] = walk_fin.sign ? UNIT : -UNIT;
			end else begin
				nrm[a] = '0;
			end
		end
	end

	assign out_valid = out_valid_q;

endmodule

FILE: rtl/core/ray_box_slab_intersect.sv
// ----------------------------------------------------------------------------
// ray_box_slab_intersect - ray against axis-aligned box, slab test
// Path from accept: input register, queue, dividers, saturate, order, walk to the output register.
// Throughput: one ray per cycle while the output is not stalled, set by the six bit-per-stage divider pipelines.
// Reset clears all valid flags and the queue pointers; no clearing pass.
// ----------------------------------------------------------------------------
module ray_box_slab_intersect #(
	parameter int COORD_WIDTH   = rbsi_pkg::COORD_WIDTH_DEF,
	parameter int FRACTION_BITS = rbsi_pkg::FRACTION_BITS_DEF
) (
	input  logic                                     clk,
	input  logic                                     arst_n,
	input  logic                                     in_valid,
	output logic                                     in_stall,
	input  logic signed [rbsi_pkg::FIELD_WIDTH-1:0]  origin_x,
	input  logic signed [rbsi_pkg::FIELD_WIDTH-1:0]  org_y,
	input  logic signed [rbsi_pkg::FIELD_WIDTH-1:0]  origin_z,
	input  logic signed [rbsi_pkg::FIELD_WIDTH-1:0]  dir_x,
	input  logic signed [rbsi_pkg::FIELD_WIDTH-1:0]  dir_y,
	input  logic signed [rbsi_pkg::FIELD_WIDTH-1:0]  dir_z,
	input  logic signed [rbsi_pkg::FIELD_WIDTH-1:0]  box_min_x,
	input  logic signed [rbsi_pkg::FIELD_WIDTH-1:0]  box_min_y,
	input  logic signed [rbsi_pkg::FIELD_WIDTH-1:0]  box_min_z,
	input  logic signed [rbsi_pkg::FIELD_WIDTH-1:0]  box_max_x,
	input  logic signed [rbsi_pkg::PAIR_WIDTH-1:0]   box_max_yz_pair,
	input  logic [rbsi_pkg::DIST_WIDTH-1:0]          dist_limit,
	output logic                                     out_valid,
	input  logic                                     out_stall,
	output logic                                     hit,
	output logic [rbsi_pkg::DIST_WIDTH-1:0]          entry_distance,
	output logic signed [rbsi_pkg::FIELD_WIDTH-1:0]  normal_x,
	output logic signed [rbsi_pkg::FIELD_WIDTH-1:0]  normal_y,
	output logic signed [rbsi_pkg::FIELD_WIDTH-1:0]  normal_z
);
	import rbsi_pkg::*;

	localparam int EW = entry_w(COORD_WIDTH);

	// Front side: one input register, then classification feeds the queue.
	logic          push;
	logic          pop;
	logic [EW-1:0] push_data;
	logic [EW-1:0] pop_data;
	fifo_status_t  status;

	rbsi_front #(
		.COORD_WIDTH   (COORD_WIDTH)
	) u_front (
		.clk             (clk),
		.arst_n          (arst_n),
		.in_valid        (in_valid),
		.in_stall        (in_stall),
		.origin_x        (origin_x),
		.org_y           (org_y),
		.origin_z        (origin_z),
		.dir_x           (dir_x),
		.dir_y           (dir_y),
		.dir_z           (dir_z),
		.box_min_x       (box_min_x),
		.box_min_y       (box_min_y),
		.box_min_z       (box_min_z),
		.box_max_x       (box_max_x),
		.box_max_yz_pair (box_max_yz_pair),
		.dist_limit      (dist_limit),
		.push            (push),
		.push_data       (push_data),
		.status          (status)
	);

	// Queue decouples the two sides; a held output stalls the front only once the queue is full.
	rbsi_fifo #(
		.WIDTH (EW)
	) u_fifo (
		.clk       (clk),
		.arst_n    (arst_n),
		.push      (push),
		.push_data (push_data),
		.pop       (pop),
		.pop_data  (pop_data),
		.status    (status)
	);

	// Back side: the whole pipeline advances whenever the output beat can move.
	rbsi_back #(
		.COORD_WIDTH   (COORD_WIDTH),
		.FRACTION_BITS (FRACTION_BITS)
	) u_back (
		.clk            (clk),
		.arst_n         (arst_n),
		.status         (status),
		.pop            (pop),
		.pop_data       (pop_data),
		.out_valid      (out_valid),
		.out_stall      (out_stall),
		.hit            (hit),
		.entry_distance (entry_distance),
		.normal_x       (normal_x),
		.normal_y       (normal_y),
		.normal_z       (normal_z)
	);

endmodule

FILE: rtl/core/rbsi_checker.sv
// ----------------------------------------------------------------------------
// rbsi_checker
// Port-level checks on result beats of the slab test.
// ----------------------------------------------------------------------------
`include "ray_box_slab_intersect_macros.svh"

module rbsi_checker (
	input logic                                     clk,
	input logic                                     arst_n,
	input logic                                     out_valid,
	input logic                                     out_stall,
	input logic                                     hit,
	input logic [rbsi_pkg::DIST_WIDTH-1:0]          entry_distance,
	input logic signed [rbsi_pkg::FIELD_WIDTH-1:0]  normal_x,
	input logic signed [rbsi_pkg::FIELD_WIDTH-1:0]  normal_y,
	input logic signed [rbsi_pkg::FIELD_WIDTH-1:0]  normal_z
);
	// a held beat stays offered
	`RBSI_ASSERT_NEXT(a_hold_valid, clk, arst_n, out_valid && out_stall, out_valid)
	// a miss reports nothing but zeros
	`RBSI_ASSERT_IMPL(a_miss_zero, clk, arst_n, out_valid && !hit, (entry_distance == '0) && (normal_x == '0) && (normal_y == '0) && (normal_z == '0))
	// a raised entry distance names exactly one face
	`RBSI_ASSERT_IMPL(a_one_face, clk, arst_n, out_valid && hit && (entry_distance != '0), $countones({normal_x != '0, normal_y != '0, normal_z != '0}) == 1)

endmodule

bind ray_box_slab_intersect rbsi_checker u_rbsi_checker (
	.clk            (clk),
	.arst_n         (arst_n),
	.out_valid      (out_valid),
	.out_stall      (out_stall),
	.hit            (hit),
	.entry_distance (entry_distance),
	.normal_x       (normal_x),
	.normal_y       (normal_y),
	.normal_z       (normal_z)
);

FILE: test/ray_box_slab_checker.sv
// ----------------------------------------------------------------------------
// ray_box_slab_checker
// Watches both channels of the slab test block, computes the expected hit,
// entry distance and normal for every accepted ray, and compares each result.
// ----------------------------------------------------------------------------
module ray_box_slab_checker (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        in_valid,
	input  logic        in_stall,
	input  logic [31:0] origin_x,
	input  logic [31:0] org_y,
	input  logic [31:0] origin_z,
	input  logic [31:0] dir_x,
	input  logic [31:0] dir_y,
	input  logic [31:0] dir_z,
	input  logic [31:0] box_min_x,
	input  logic [31:0] box_min_y,
	input  logic [31:0] box_min_z,
	input  logic [31:0] box_max_x,
	input  logic [63:0] box_max_yz_pair,
	input  logic [30:0] dist_limit,
	input  logic        out_valid,
	input  logic        out_stall,
	input  logic        hit,
	input  logic [30:0] entry_distance,
	input  logic [31:0] normal_x,
	input  logic [31:0] normal_y,
	input  logic [31:0] normal_z,
	output int          fail_count,
	output int          pending
);
	timeunit 1ns;
	timeprecision 1ps;

	localparam longint CMAX = 64'sd2147483647;
	localparam longint CMIN = -64'sd2147483648;
	localparam longint UNIT = 64'sd65536;

	typedef struct packed {
		logic        hit;
		logic [30:0] t_entry;
		logic [31:0] nx;
		logic [31:0] ny;
		logic [31:0] nz;
	} hit_record_t;

	hit_record_t expected_hits[$];

	function automatic longint clamp32(input longint v);
		if (v > CMAX) return CMAX;
		if (v < CMIN) return CMIN;
		return v;
	endfunction

	function automatic hit_record_t trace_ray(
		input logic [31:0] ox, oy, oz, dx, dy, dz, lx, ly, lz, hx,
		input logic [63:0] hyz, input logic [30:0] lim);
		longint o[3], d[3], lo[3], hi[3];
		longint t_near, t_far, t0, t1, s, sgn, tmp;
		int axis;
		longint n[3];
		hit_record_t r;
		o[0] = longint'(signed'(ox)); o[1] = longint'(signed'(oy)); o[2] = longint'(signed'(oz));
		d[0] = longint'(signed'(dx)); d[1] = longint'(signed'(dy)); d[2] = longint'(signed'(dz));
		lo[0] = longint'(signed'(lx)); lo[1] = longint'(signed'(ly));
		lo[2] = longint'(signed'(lz));
		hi[0] = longint'(signed'(hx));
		hi[1] = longint'(signed'(hyz[63:32]));
		hi[2] = longint'(signed'(hyz[31:0]));
		r = '0;
		t_near = 0;
		t_far = longint'({1'b0, lim});
		axis = -1;
		sgn = 1;
		for (int a = 0; a < 3; a++) begin
			if (d[a] == 0) begin
				if (o[a] < lo[a] || o[a] > hi[a]) return r;
				continue;
			end
			t0 = clamp32(((lo[a] - o[a]) * UNIT) / d[a]);
			t1 = clamp32(((hi[a] - o[a]) * UNIT) / d[a]);
			s = -1;
			if (t0 > t1) begin
				tmp = t0; t0 = t1; t1 = tmp; s = 1;
			end
			if (t0 > t_near) begin
				t_near = t0; axis = a; sgn = s;
			end
			if (t1 < t_far) t_far = t1;
			if (t_near > t_far) return r;
		end
		n[0] = 0; n[1] = 0; n[2] = 0;
		if (axis >= 0) n[axis] = sgn * UNIT;
		else for (int a = 0; a < 3; a++) n[a] = clamp32(-d[a]);
		r.hit = 1'b1;
		r.t_entry = t_near[30:0];
		r.nx = n[0][31:0];
		r.ny = n[1][31:0];
		r.nz = n[2][31:0];
		return r;
	endfunction

	assign pending = expected_hits.size();

	always @(posedge clk or negedge arst_n) begin
		hit_record_t e;
		if (!arst_n) begin
			fail_count <= 0;
		end else begin
			if (in_valid && !in_stall)
				expected_hits.insert(expected_hits.size(), trace_ray(origin_x, org_y, origin_z,
					dir_x, dir_y, dir_z, box_min_x, box_min_y, box_min_z, box_max_x,
					box_max_yz_pair, dist_limit));
			if (out_valid && !out_stall) begin
				if (expected_hits.size() == 0) begin
					$error("result beat with nothing expected");
					fail_count <= fail_count + 1;
				end else begin
					e = expected_hits.pop_front();
					if (e.hit !== hit || e.t_entry !== entry_distance || e.nx !== normal_x ||
							e.ny !== normal_y || e.nz !== normal_z) begin
						if (e.hit !== hit)
							$error("hit: expected %0d actual %0d", e.hit, hit);
						if (e.t_entry !== entry_distance)
							$error("entry_distance: expected %0h actual %0h", e.t_entry,
								entry_distance);
						if (e.nx !== normal_x)
							$error("normal_x: expected %0h actual %0h", e.nx, normal_x);
						if (e.ny !== normal_y)
							$error("normal_y: expected %0h actual %0h", e.ny, normal_y);
						if (e.nz !== normal_z)
							$error("normal_z: expected %0h actual %0h", e.nz, normal_z);
						fail_count <= fail_count + 1;
					end
				end
			end
		end
	end
endmodule

FILE: test/tb_ray_box_slab_intersect.sv
// ----------------------------------------------------------------------------
// tb_ray_box_slab_intersect
// Drives rays and boxes into the slab test block with random gaps and stalls;
// the checker beside the block predicts and compares every result beat.
// ----------------------------------------------------------------------------
module tb_ray_box_slab_intersect;
	timeunit 1ns;
	timeprecision 1ps;

	localparam int RANDOM_RAYS = 1700;
	localparam int WATCHDOG_LIMIT = 20000;
	localparam int DRAIN_CYCLES = 120;

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic in_valid = 1'b0;
	logic in_stall;
	logic [31:0] origin_x = '0, org_y = '0, origin_z = '0;
	logic [31:0] dir_x = '0, dir_y = '0, dir_z = '0;
	logic [31:0] box_min_x = '0, box_min_y = '0, box_min_z = '0, box_max_x = '0;
	logic [63:0] box_max_yz_pair = '0;
	logic [30:0] dist_limit = '0;
	logic out_valid;
	logic out_stall = 1'b1;
	logic hit;
	logic [30:0] entry_distance;
	logic [31:0] normal_x, normal_y, normal_z;
	int fail_count, pending;

	// idle rates in percent, changed per phase
	int send_idle_pct = 21;
	int recv_idle_pct = 63;
	bit long_hold = 1'b0;
	int idle_cycles = 0;

	always #4 clk = ~clk;

	ray_box_slab_intersect dut (.*);

	ray_box_slab_checker checker_i (.*);

	// receiver: random stall, with one long hold-off so the pipeline backs up
	always @(negedge clk) begin
		if (!arst_n) out_stall <= 1'b1;
		else if (long_hold) out_stall <= 1'b1;
		else out_stall <= ($urandom_range(99) < recv_idle_pct);
	end

	// watchdog: count cycles with no accepted beat on either channel
	always @(posedge clk) begin
		if ((in_valid && !in_stall) || (out_valid && !out_stall)) idle_cycles <= 0;
		else idle_cycles <= idle_cycles + 1;
		if (idle_cycles >= WATCHDOG_LIMIT) begin
			$display("tb_ray_box_slab_intersect: errors");
			$finish;
		end
	end

	// pick a coordinate: mostly small values so slabs actually overlap
	function automatic logic [31:0] pick_coord();
		case ($urandom_range(9))
			0: return 32'h8000_0000;
			1: return 32'h7fff_ffff;
			2: return $urandom();
			3: return 32'h0;
			default: return 32'($signed($urandom_range(2 * 655360)) - 655360);
		endcase
	endfunction

	function automatic logic [31:0] pick_dir();
		case ($urandom_range(9))
			0: return 32'h0;
			1: return 32'h8000_0000;
			2: return 32'h7fff_ffff;
			3: return $urandom();
			4: return 32'h1;
			default: return 32'($signed($urandom_range(2 * 131072)) - 131072);
		endcase
	endfunction

	// hold a beat on the input until accepted
	task automatic send_ray(input logic [31:0] ox, oy, oz, dx, dy, dz, lx, ly, lz, hx,
			input logic [63:0] hyz, input logic [30:0] lim);
		while ($urandom_range(99) < send_idle_pct) begin
			in_valid <= 1'b0;
			@(negedge clk);
		end
		in_valid <= 1'b1;
		origin_x <= ox; org_y <= oy; origin_z <= oz;
		dir_x <= dx; dir_y <= dy; dir_z <= dz;
		box_min_x <= lx; box_min_y <= ly; box_min_z <= lz;
		box_max_x <= hx; box_max_yz_pair <= hyz; dist_limit <= lim;
		@(posedge clk);
		while (in_stall) @(posedge clk);
		@(negedge clk);
	endtask

	// random box and a separately picked random origin; sometimes inverted or degenerate
	task automatic send_random_ray();
		logic [31:0] lo[3], hi[3], t;
		logic [30:0] lim;
		for (int a = 0; a < 3; a++) begin
			lo[a] = pick_coord();
			hi[a] = pick_coord();
			if ($urandom_range(9) > 1 && $signed(lo[a]) > $signed(hi[a])) begin
				t = lo[a]; lo[a] = hi[a]; hi[a] = t;
			end
		end
		case ($urandom_range(3))
			0: lim = 31'($urandom());
			1: lim = 31'h7fff_ffff;
			2: lim = 31'h0;
			default: lim = 31'($urandom_range(4000000));
		endcase
		send_ray(pick_coord(), pick_coord(), pick_coord(), pick_dir(), pick_dir(), pick_dir(),
			lo[0], lo[1], lo[2], hi[0], {hi[1], hi[2]}, lim);
	endtask

	initial begin
		int hold;
		repeat (4) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;
		@(negedge clk);
		// directed: unit box, rays along each axis, both signs
		send_ray(32'hfffe_0000, 32'h8000, 32'h8000, 32'h1_0000, 0, 0, 0, 0, 0,
			32'h1_0000, {32'h1_0000, 32'h1_0000}, 31'h7fff_ffff);
		send_ray(32'h8000, 32'h3_0000, 32'h8000, 0, 32'hffff_0000, 0, 0, 0, 0,
			32'h1_0000, {32'h1_0000, 32'h1_0000}, 31'h7fff_ffff);
		send_ray(32'h8000, 32'h8000, 32'hfff0_0000, 0, 0, 32'h2_0000, 0, 0, 0,
			32'h1_0000, {32'h1_0000, 32'h1_0000}, 31'h7fff_ffff);
		// origin inside, normal is negated direction, with most negative dir
		send_ray(32'h8000, 32'h8000, 32'h8000, 32'h8000_0000, 32'h7fff_ffff, 32'h1234, 0, 0, 0,
			32'h1_0000, {32'h1_0000, 32'h1_0000}, 31'h100);
		// parallel miss and parallel inside on every axis
		send_ray(32'h2_0000, 0, 0, 0, 32'h1_0000, 32'h1_0000, 0, 0, 0,
			32'h1_0000, {32'h1_0000, 32'h1_0000}, 31'h7fff_ffff);
		send_ray(0, 32'hffff_0000, 0, 32'h1_0000, 0, 32'h1_0000, 0, 0, 0,
			32'h1_0000, {32'h1_0000, 32'h1_0000}, 31'h7fff_ffff);
		send_ray(0, 0, 32'h5_0000, 32'h1_0000, 32'h1_0000, 0, 0, 0, 0,
			32'h1_0000, {32'h1_0000, 32'h1_0000}, 31'h7fff_ffff);
		send_ray(0, 0, 0, 0, 0, 0, 0, 0, 0, 0, 64'h0, 31'h0);
		// tie on all axes: diagonal ray, earliest axis wins
		send_ray(32'hffff_0000, 32'hffff_0000, 32'hffff_0000, 32'h1_0000, 32'h1_0000,
			32'h1_0000, 0, 0, 0, 32'h1_0000, {32'h1_0000, 32'h1_0000}, 31'h7fff_ffff);
		// beyond the limit
		send_ray(32'hfff0_0000, 32'h8000, 32'h8000, 32'h1_0000, 0, 0, 0, 0, 0,
			32'h1_0000, {32'h1_0000, 32'h1_0000}, 31'h1_0000);
		// saturating quotients and extreme fields
		send_ray(32'h8000_0000, 32'h8000_0000, 32'h8000_0000, 32'h1, 32'h1, 32'h1,
			32'h7fff_ffff, 32'h7fff_ffff, 32'h7fff_ffff, 32'h8000_0000,
			64'h8000_0000_8000_0000, 31'h7fff_ffff);
		send_ray(32'h7fff_ffff, 32'h7fff_ffff, 32'h7fff_ffff, 32'hffff_ffff, 32'hffff_ffff,
			32'hffff_ffff, 32'h8000_0000, 32'h8000_0000, 32'h8000_0000, 32'h7fff_ffff,
			64'h7fff_ffff_7fff_ffff, 31'h7fff_ffff);
		// inverted box
		send_ray(32'hfffe_0000, 32'h8000, 32'h8000, 32'h1_0000, 0, 0, 32'h1_0000, 0, 0,
			0, {32'h1_0000, 32'h1_0000}, 31'h7fff_ffff);
		for (int phase = 0; phase < 3; phase++) begin
			send_idle_pct = (phase == 0) ? 21 : (phase == 1) ? 63 : 0;
			recv_idle_pct = (phase == 0) ? 63 : (phase == 1) ? 21 : 0;
			for (int i = 0; i < RANDOM_RAYS / 3; i++) begin
				// long hold-off in the last phase, starting at ray 100
				if (phase == 2 && i == 100) begin
					long_hold = 1'b1;
					fork
						begin
							hold = 0;
							while (hold < 300) begin
								@(posedge clk);
								hold++;
							end
							long_hold = 1'b0;
						end
					join_none
				end
				send_random_ray();
			end
		end
		in_valid <= 1'b0;
		while (pending != 0) @(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);
		if (fail_count == 0 && pending == 0)
			$display("tb_ray_box_slab_intersect: clean");
		else
			$display("tb_ray_box_slab_intersect: errors");
		$finish;
	end
endmodule
